FILE: rtl/core/mccw_pkg.sv
// Shared types and constants for the midpoint circle cell writer.
// No dependencies; used by every module in rtl/core.
package mccw_pkg;

   localparam int MaxRadius    = 10;
   localparam int MaxGridWidth = 1024;
   localparam int QueueDepth   = 2;

   localparam int CoordW  = 12;   // centre coordinates
   localparam int PointW  = 13;   // centre plus offset, signed
   localparam int RadiusW = 4;
   localparam int GridW   = 11;
   localparam int AddrW   = 20;
   localparam int DecW    = 7;
   localparam int StepW   = 3;    // at most eight steps per circle
   localparam int OctW    = 3;

   localparam logic [GridW-1:0]   GridWidthReset = GridW'(MaxGridWidth);
   localparam logic [RadiusW-1:0] MaxRadiusVal   = RadiusW'(MaxRadius);
   localparam logic [StepW-1:0]   LastStep       = '1;
   localparam logic [OctW-1:0]    LastOct        = '1;

   typedef struct packed {
      logic signed [CoordW-1:0] center_col;
      logic signed [CoordW-1:0] center_row;
      logic        [RadiusW-1:0] radius;
   } circle_type;

   typedef struct packed {
      logic signed [PointW-1:0] col;
      logic signed [PointW-1:0] row;
      logic                     last;
   } point_type;

endpackage

FILE: rtl/core/midpoint_circle_cell_writer.sv
// Midpoint circle cell writer: rasterises a circle (signed centre, radius up to
// 10 cells, larger radii clamp to 10) onto a square grid of csr_wr_data cells a
// side, width clamped to 1024. Each step of the walk gives eight points, at most
// eight steps, so up to 64 results: cell_address = row*width+col, in_bounds, and
// last_point on the final one. Results leave at one per cycle from the stepper
// through a two-stage address pipeline unless a full output stalls; a circle is
// loaded while idle, then stepped. A two-entry queue holds waiting circles.
// Depends on mccw_pkg, mccw_front, mccw_stepper and mccw_addr.
module midpoint_circle_cell_writer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [mccw_pkg::CoordW-1:0]  req_center_col,
   input  logic signed [mccw_pkg::CoordW-1:0]  req_center_row,
   input  logic        [mccw_pkg::RadiusW-1:0] req_radius_cells,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [mccw_pkg::AddrW-1:0]          rsp_cell_address,
   output logic                                rsp_in_bounds,
   output logic                                rsp_last_point,
   input  logic                                csr_wr_en,
   input  logic [mccw_pkg::GridW-1:0]          csr_wr_data
);

   logic [mccw_pkg::GridW-1:0] grid_width_ff, grid_width_in;
   logic                       cq_valid, cq_pop;
   mccw_pkg::circle_type       cq_circle;
   logic                       pt_valid, pt_ready;
   mccw_pkg::point_type        pt_data;

   assign grid_width_in = csr_wr_en ? csr_wr_data : grid_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= mccw_pkg::GridWidthReset;
      end else begin
         grid_width_ff <= grid_width_in;
      end
   end

   mccw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_center_col   (req_center_col),
      .req_center_row   (req_center_row),
      .req_radius_cells (req_radius_cells),
      .cq_valid         (cq_valid),
      .cq_circle        (cq_circle),
      .cq_pop           (cq_pop)
   );

   mccw_stepper u_stepper (
      .clock     (clock),
      .reset     (reset),
      .cq_valid  (cq_valid),
      .cq_circle (cq_circle),
      .cq_pop    (cq_pop),
      .pt_valid  (pt_valid),
      .pt_data   (pt_data),
      .pt_ready  (pt_ready)
   );

   mccw_addr u_addr (
      .clock            (clock),
      .reset            (reset),
      .grid_width       (grid_width_ff),
      .pt_valid         (pt_valid),
      .pt_data          (pt_data),
      .pt_ready         (pt_ready),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_cell_address (rsp_cell_address),
      .rsp_in_bounds    (rsp_in_bounds),
      .rsp_last_point   (rsp_last_point)
   );

endmodule

FILE: rtl/core/mccw_front.sv
// Front end: takes circle transactions, saturates the radius and queues them.
// Depends on mccw_pkg.
module mccw_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic signed [mccw_pkg::CoordW-1:0]  req_center_col,
   input  logic signed [mccw_pkg::CoordW-1:0]  req_center_row,
   input  logic        [mccw_pkg::RadiusW-1:0] req_radius_cells,
   output logic                            cq_valid,
   output mccw_pkg::circle_type            cq_circle,
   input  logic                            cq_pop
);

   mccw_pkg::circle_type entry_ff [mccw_pkg::QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   mccw_pkg::circle_type incoming;
   logic       do_push, do_pop;

   always_comb begin
      incoming.center_col = req_center_col;
      incoming.center_row = req_center_row;
      incoming.radius     = (req_radius_cells > mccw_pkg::MaxRadiusVal)
                            ? mccw_pkg::MaxRadiusVal : req_radius_cells;
   end

   assign req_full  = (count_ff == 2'(mccw_pkg::QueueDepth));
   assign cq_valid  = (count_ff != 2'd0);
   assign cq_circle = entry_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cq_pop && cq_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

FILE: rtl/core/mccw_stepper.sv
// Back end stepper: walks the midpoint circle and produces eight points per step.
// Depends on mccw_pkg.
module mccw_stepper (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cq_valid,
   input  mccw_pkg::circle_type  cq_circle,
   output logic                  cq_pop,
   output logic                  pt_valid,
   output mccw_pkg::point_type   pt_data,
   input  logic                  pt_ready
);

   logic                                 busy_ff, busy_in;
   logic                                 first_ff, first_in;
   logic [mccw_pkg::RadiusW-1:0]         x_ff, x_in;
   logic [mccw_pkg::RadiusW-1:0]         y_ff, y_in;
   logic signed [mccw_pkg::DecW-1:0]     d_ff, d_in;
   logic [mccw_pkg::OctW-1:0]            oct_ff, oct_in;
   logic [mccw_pkg::StepW-1:0]           step_ff, step_in;
   logic signed [mccw_pkg::CoordW-1:0]   ccol_ff, ccol_in;
   logic signed [mccw_pkg::CoordW-1:0]   crow_ff, crow_in;

   logic [mccw_pkg::RadiusW-1:0]         a, b, dc, dr, y1, x1;
   logic signed [mccw_pkg::PointW-1:0]   dc_s, dr_s;
   logic signed [mccw_pkg::DecW-1:0]     diff;
   logic                                 more_steps, emit;

   // first step walks (x,y), later steps the swapped pair (y,x)
   always_comb begin
      a    = first_ff ? x_ff : y_ff;
      b    = first_ff ? y_ff : x_ff;
      dc   = oct_ff[2] ? b : a;
      dr   = oct_ff[2] ? a : b;
      dc_s = $signed({{(mccw_pkg::PointW-mccw_pkg::RadiusW){1'b0}}, dc});
      dr_s = $signed({{(mccw_pkg::PointW-mccw_pkg::RadiusW){1'b0}}, dr});
      more_steps = (y_ff < x_ff) && (step_ff != mccw_pkg::LastStep);

      pt_valid     = busy_ff;
      pt_data.col  = oct_ff[0] ? (mccw_pkg::PointW'(ccol_ff) - dc_s)
                               : (mccw_pkg::PointW'(ccol_ff) + dc_s);
      pt_data.row  = oct_ff[1] ? (mccw_pkg::PointW'(crow_ff) - dr_s)
                               : (mccw_pkg::PointW'(crow_ff) + dr_s);
      pt_data.last = (oct_ff == mccw_pkg::LastOct) && !more_steps;
   end

   assign emit   = busy_ff && pt_ready;
   assign cq_pop = !busy_ff && cq_valid;

   always_comb begin
      y1   = y_ff + 4'd1;
      x1   = x_ff - 4'd1;
      diff = $signed({3'b000, y1}) - $signed({3'b000, x1});

      busy_in  = busy_ff;
      first_in = first_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      d_in     = d_ff;
      oct_in   = oct_ff;
      step_in  = step_ff;
      ccol_in  = ccol_ff;
      crow_in  = crow_ff;

      if (cq_pop) begin
         busy_in  = 1'b1;
         first_in = 1'b1;
         x_in     = cq_circle.radius;
         y_in     = '0;
         d_in     = mccw_pkg::DecW'(1) - $signed({3'b000, cq_circle.radius});
         oct_in   = '0;
         step_in  = '0;
         ccol_in  = cq_circle.center_col;
         crow_in  = cq_circle.center_row;
      end else if (emit) begin
         oct_in = oct_ff + 3'd1;
         if (oct_ff == mccw_pkg::LastOct) begin
            if (more_steps) begin
               first_in = 1'b0;
               step_in  = step_ff + 3'd1;
               y_in     = y1;
               if (d_ff < 0) begin
                  d_in = d_ff + $signed({2'b00, y1, 1'b1});
               end else begin
                  x_in = x1;
                  d_in = d_ff + ((diff <<< 1) | 7'sd1);
               end
            end else begin
               busy_in  = 1'b0;
               first_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         first_ff <= 1'b1;
         x_ff     <= '0;
         y_ff     <= '0;
         d_ff     <= '0;
         oct_ff   <= '0;
         step_ff  <= '0;
         ccol_ff  <= '0;
         crow_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         first_ff <= first_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         d_ff     <= d_in;
         oct_ff   <= oct_in;
         step_ff  <= step_in;
         ccol_ff  <= ccol_in;
         crow_ff  <= crow_in;
      end
   end

`ifndef SYNTH
   a_oct_idle : assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (oct_ff == '0))
      else $error("octant counter moved while idle");
   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      (emit && pt_data.last) |=> !busy_ff)
      else $error("stepper still busy after last point");
   a_first_step : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && first_ff) |-> (step_ff == '0) && (y_ff == '0))
      else $error("first step flag out of step with counters");
   a_no_load_busy : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cq_pop)
      else $error("circle taken while one is in progress");
`endif

endmodule

FILE: rtl/core/mccw_addr.sv
// Back end address unit: bounds check and row*width+col, with the result register.
// Depends on mccw_pkg.
module mccw_addr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [mccw_pkg::GridW-1:0]      grid_width,
   input  logic                            pt_valid,
   input  mccw_pkg::point_type             pt_data,
   output logic                            pt_ready,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [mccw_pkg::AddrW-1:0]      rsp_cell_address,
   output logic                            rsp_in_bounds,
   output logic                            rsp_last_point
);

   logic                              s1_valid_ff, s1_valid_in;
   mccw_pkg::point_type               s1_pt_ff;
   logic                              out_valid_ff, out_valid_in;
   logic [mccw_pkg::AddrW-1:0]        out_addr_ff;
   logic                              out_inb_ff, out_last_ff;
   logic                              out_ready, s1_ready, s1_move;
   logic [mccw_pkg::GridW-1:0]        w_eff;
   logic                              ok;
   logic [mccw_pkg::AddrW:0]          addr_full;

   assign out_ready = !out_valid_ff || rsp_pop;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign pt_ready  = s1_ready;
   assign s1_move   = s1_valid_ff && out_ready;

   always_comb begin
      w_eff = (grid_width > mccw_pkg::GridWidthReset) ? mccw_pkg::GridWidthReset : grid_width;
      ok = !s1_pt_ff.col[mccw_pkg::PointW-1] && !s1_pt_ff.row[mccw_pkg::PointW-1]
           && (s1_pt_ff.col[mccw_pkg::PointW-2:0] < {1'b0, w_eff})
           && (s1_pt_ff.row[mccw_pkg::PointW-2:0] < {1'b0, w_eff});
      // in bounds implies row and col below 1024, so ten bits of each suffice
      addr_full = (mccw_pkg::AddrW+1)'(mccw_pkg::AddrW'(s1_pt_ff.row[9:0])
                                       * mccw_pkg::AddrW'(w_eff))
                  + (mccw_pkg::AddrW+1)'(s1_pt_ff.col[9:0]);
      s1_valid_in  = pt_valid ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_move ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_ready ? s1_valid_in : s1_valid_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pt_valid && s1_ready) begin
         s1_pt_ff <= pt_data;
      end
      if (s1_move) begin
         out_addr_ff <= ok ? addr_full[mccw_pkg::AddrW-1:0] : '0;
         out_inb_ff  <= ok;
         out_last_ff <= s1_pt_ff.last;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_cell_address = out_addr_ff;
   assign rsp_in_bounds    = out_inb_ff;
   assign rsp_last_point   = out_last_ff;

endmodule
